// File: rtl/dtpv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtpv_pkg
// Shared types, constants and calendar helpers for the date text parser.
// ----------------------------------------------------------------------------
package dtpv_pkg;

  localparam int unsigned CharWidth   = 8;
  localparam int unsigned LenWidth    = 4;
  localparam int unsigned PackedWidth = 27;
  localparam int unsigned YearWidth   = 14;

  localparam logic [CharWidth-1:0]   AsciiZero = 8'd48;
  localparam logic [CharWidth-1:0]   AsciiNine = 8'd57;
  localparam logic [CharWidth-1:0]   AsciiDash = 8'd45;

  localparam logic [LenWidth-1:0]    LenShort  = 4'd8;
  localparam logic [LenWidth-1:0]    LenMid    = 4'd9;
  localparam logic [LenWidth-1:0]    LenFull   = 4'd10;

  localparam logic [YearWidth-1:0]   YearMin   = 14'd1970;
  localparam logic [YearWidth-1:0]   YearMax   = 14'd2038;

  localparam logic [PackedWidth-1:0] PackedMin = 27'd19700101;
  localparam logic [PackedWidth-1:0] PackedMax = 27'd20381231;

  typedef logic [3:0] digit_t;

  // Digits picked out of the text for one item, most significant first.
  typedef struct packed {
    digit_t [3:0] year;
    digit_t       mon_t;
    digit_t       mon_u;
    digit_t       day_t;
    digit_t       day_u;
    logic         digits_ok;
  } dtpv_fields_t;

  function automatic logic is_digit(input logic [CharWidth-1:0] c);
    return (c >= AsciiZero) && (c <= AsciiNine);
  endfunction

  function automatic digit_t digit_of(input logic [CharWidth-1:0] c);
    logic [CharWidth-1:0] v;
    v = c - AsciiZero;
    return v[3:0];
  endfunction

  // Two decimal digits to a binary value of 0..99.
  function automatic logic [6:0] pair_value(input digit_t t, input digit_t u);
    return 7'(t) * 7'd10 + 7'(u);
  endfunction

  // Gregorian rule on the two-digit halves of the year.
  function automatic logic leap_year(input logic [6:0] cent, input logic [6:0] yy);
    logic leap;
    if (yy == 7'd0) begin
      leap = (cent[1:0] == 2'b00);
    end else begin
      leap = (yy[1:0] == 2'b00);
    end
    return leap;
  endfunction

  function automatic logic [4:0] month_days(input logic [6:0] mon, input logic leap);
    logic [4:0] days;
    case (mon)
      7'd2:    days = leap ? 5'd29 : 5'd28;
      7'd4,
      7'd6,
      7'd9,
      7'd11:   days = 5'd30;
      default: days = 5'd31;
    endcase
    return days;
  endfunction

endpackage
`default_nettype wire

// File: rtl/dtpv_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtpv_decode
// Selects the layout from the length and extracts the year, month and day
// digits, flagging any non-digit in a digit position or a bad length.
// ----------------------------------------------------------------------------
module dtpv_decode (
  input  wire logic [dtpv_pkg::CharWidth-1:0] chars [10],
  input  wire logic [dtpv_pkg::LenWidth-1:0]  text_length,
  output dtpv_pkg::dtpv_fields_t              fields
);
  import dtpv_pkg::*;

  logic len_ok;
  logic dash_at_6;
  logic year_ok;
  logic layout_ok;

  assign len_ok    = (text_length == LenShort) || (text_length == LenMid) ||
                     (text_length == LenFull);
  assign dash_at_6 = (chars[6] == AsciiDash);
  assign year_ok   = is_digit(chars[0]) && is_digit(chars[1]) &&
                     is_digit(chars[2]) && is_digit(chars[3]) && is_digit(chars[5]);

  always_comb begin
    fields.year[3] = digit_of(chars[0]);
    fields.year[2] = digit_of(chars[1]);
    fields.year[1] = digit_of(chars[2]);
    fields.year[0] = digit_of(chars[3]);
    fields.mon_t   = '0;
    fields.mon_u   = digit_of(chars[5]);
    fields.day_t   = '0;
    fields.day_u   = digit_of(chars[7]);
    layout_ok      = is_digit(chars[7]);
    if (text_length == LenFull) begin
      fields.mon_t = digit_of(chars[5]);
      fields.mon_u = digit_of(chars[6]);
      fields.day_t = digit_of(chars[8]);
      fields.day_u = digit_of(chars[9]);
      layout_ok    = is_digit(chars[6]) && is_digit(chars[8]) && is_digit(chars[9]);
    end else if (text_length == LenMid) begin
      if (dash_at_6) begin
        fields.day_t = digit_of(chars[7]);
        fields.day_u = digit_of(chars[8]);
        layout_ok    = is_digit(chars[7]) && is_digit(chars[8]);
      end else begin
        fields.mon_t = digit_of(chars[5]);
        fields.mon_u = digit_of(chars[6]);
        fields.day_u = digit_of(chars[8]);
        layout_ok    = is_digit(chars[6]) && is_digit(chars[8]);
      end
    end
    fields.digits_ok = len_ok && year_ok && layout_ok;
  end

endmodule
`default_nettype wire

// File: rtl/dtpv_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtpv_check
// Checks the calendar rules on the extracted digits and forms the packed
// YYYYMMDD value as a weighted sum of the digits.
// ----------------------------------------------------------------------------
module dtpv_check (
  input  wire dtpv_pkg::dtpv_fields_t           fields,
  output logic [dtpv_pkg::PackedWidth-1:0]      packed_value,
  output logic                                  valid
);
  import dtpv_pkg::*;

  logic [6:0]             cent;
  logic [6:0]             yy;
  logic [YearWidth-1:0]   year;
  logic [6:0]             mon;
  logic [6:0]             day;
  logic [4:0]             days_in_month;
  logic [PackedWidth-1:0] sum;

  assign cent = pair_value(fields.year[3], fields.year[2]);
  assign yy   = pair_value(fields.year[1], fields.year[0]);
  assign year = YearWidth'(cent) * YearWidth'(100) + YearWidth'(yy);
  assign mon  = pair_value(fields.mon_t, fields.mon_u);
  assign day  = pair_value(fields.day_t, fields.day_u);

  assign days_in_month = month_days(mon, leap_year(cent, yy));

  // Each digit carries its decimal weight, so no product feeds another.
  assign sum = PackedWidth'(fields.year[3]) * PackedWidth'(10000000) +
               PackedWidth'(fields.year[2]) * PackedWidth'(1000000)  +
               PackedWidth'(fields.year[1]) * PackedWidth'(100000)   +
               PackedWidth'(fields.year[0]) * PackedWidth'(10000)    +
               PackedWidth'(fields.mon_t)   * PackedWidth'(1000)     +
               PackedWidth'(fields.mon_u)   * PackedWidth'(100)      +
               PackedWidth'(fields.day_t)   * PackedWidth'(10)       +
               PackedWidth'(fields.day_u);

  assign valid = fields.digits_ok &&
                 (year >= YearMin) && (year <= YearMax) &&
                 (mon >= 7'd1) && (mon <= 7'd12) &&
                 (day >= 7'd1) && (day <= 7'(days_in_month));

  assign packed_value = valid ? sum : '0;

endmodule
`default_nettype wire

// File: rtl/date_text_parse_validate_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// date_text_parse_validate_top
// Parses a date text of up to ten ASCII characters and checks it.
// ----------------------------------------------------------------------------
// An item is taken on every clock edge where start is high; busy stays low,
// so the block sustains one item per cycle. Each result is driven on
// packed_date and date_valid, with done high for exactly one cycle, from the
// clock edge after the one that took its item; one input register and one
// result register set this, with the parse and calendar check between them.
// Results leave in input order and cannot be held off by the receiver. An
// invalid date gives packed_date 0.
module date_text_parse_validate_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [dtpv_pkg::CharWidth-1:0]        char_0,
  input  wire logic [dtpv_pkg::CharWidth-1:0]        char_1,
  input  wire logic [dtpv_pkg::CharWidth-1:0]        char_2,
  input  wire logic [dtpv_pkg::CharWidth-1:0]        char_3,
  input  wire logic [dtpv_pkg::CharWidth-1:0]        char_4,
  input  wire logic [dtpv_pkg::CharWidth-1:0]        char_5,
  input  wire logic [dtpv_pkg::CharWidth-1:0]        char_6,
  input  wire logic [dtpv_pkg::CharWidth-1:0]        char_7,
  input  wire logic [dtpv_pkg::CharWidth-1:0]        char_8,
  input  wire logic [dtpv_pkg::CharWidth-1:0]        char_9,
  input  wire logic [dtpv_pkg::LenWidth-1:0]         text_length,
  output logic                                       done,
  output logic [dtpv_pkg::PackedWidth-1:0]           packed_date,
  output logic                                       date_valid
);
  import dtpv_pkg::*;

  logic [CharWidth-1:0]   chars [10];
  logic [LenWidth-1:0]    len;
  logic                   in_valid;
  dtpv_fields_t           fields;
  logic [PackedWidth-1:0] packed_value;
  logic                   valid;

  assign busy = 1'b0;

  // Input register. The separator at position 4 is never examined.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
    if (start) begin
      chars[0] <= char_0;
      chars[1] <= char_1;
      chars[2] <= char_2;
      chars[3] <= char_3;
      chars[4] <= char_4;
      chars[5] <= char_5;
      chars[6] <= char_6;
      chars[7] <= char_7;
      chars[8] <= char_8;
      chars[9] <= char_9;
      len      <= text_length;
    end
  end

  dtpv_decode u_decode (
    .chars       (chars),
    .text_length (len),
    .fields      (fields)
  );

  dtpv_check u_check (
    .fields       (fields),
    .packed_value (packed_value),
    .valid        (valid)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    if (in_valid) begin
      packed_date <= packed_value;
      date_valid  <= valid;
    end
  end

`ifndef SYNTHESIS
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2))
    else $error("result strobe without an item two cycles earlier");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !date_valid) |-> (packed_date == '0))
    else $error("invalid date carries a nonzero packed value");

  a_valid_in_range: assert property (@(posedge clk) disable iff (rst)
    (done && date_valid) |-> ((packed_date >= PackedMin) && (packed_date <= PackedMax)))
    else $error("valid packed date outside the allowed span");

  a_strobe_pairs_input: assert property (@(posedge clk) disable iff (rst)
    in_valid |=> done)
    else $error("captured item produced no result");
`endif

endmodule
`default_nettype wire
